FILE: rtl/moi_pkg.sv
// shared constants and helpers for the mecanum odometry integrator
// no dependencies
`timescale 1ns / 1ps

package moi_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int SPEED_W    = 32;
    localparam int GAIN_W     = 32;
    localparam int POS_W      = 48;
    localparam int TIME_W     = 63;
    localparam int MUL_W      = 34;

    // floor(2^62 / 1e9), seconds in q.30 from nanoseconds after a 32 bit shift
    localparam logic [32:0] SEC_RECIP = 33'd4611686018;

    localparam logic [1:0] OP_UPDATE    = 2'd0;
    localparam logic [1:0] OP_INIT      = 2'd1;
    localparam logic [1:0] OP_POS_RESET = 2'd2;

    localparam logic CFG_LINEAR  = 1'b0;
    localparam logic CFG_ANGULAR = 1'b1;

    // product >> 16, magnitude clamped, sign applied
    function automatic logic [31:0] vel_sat(input logic [2*MUL_W-1:0] p, input logic neg);
        logic [2*MUL_W-17:0] r;
        logic [31:0] cap;
        logic [31:0] m;
        r   = p[2*MUL_W-1:16];
        cap = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        m   = (r > {{(2*MUL_W-48){1'b0}}, cap}) ? cap : r[31:0];
        return neg ? (~m + 32'd1) : m;
    endfunction

endpackage

FILE: rtl/moi_mul.sv
// shared unsigned multiplier with registered product
// depends on moi_pkg
`timescale 1ns / 1ps

module moi_mul import moi_pkg::*;
(
    input  logic                 clk,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   p
);

    logic [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: rtl/moi_wmem.sv
// velocity window memory, one entry holds the three body velocities
// synchronous read with registered read data; depends on moi_pkg
`timescale 1ns / 1ps

module moi_wmem import moi_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEF,
    parameter int AW    = $clog2(WINDOW_DEF),
    parameter int DW    = 3 * SPEED_W
)
(
    input  logic          clk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/moi_div.sv
// three lane divider by the window length, four quotient bits per cycle
// depends on moi_pkg
`timescale 1ns / 1ps

module moi_div import moi_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int SUMW   = SPEED_W + $clog2(WINDOW_DEF)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2:0][SUMW-1:0] mag,
    output logic [2:0][31:0]     quo,
    output logic                 done
);

    localparam int DIVW  = ((SUMW + 3) / 4) * 4;
    localparam int STEPS = DIVW / 4;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int RW    = $clog2(WINDOW) + 1;

    logic [2:0][RW-1:0]   rem_reg, rem_next;
    logic [2:0][DIVW-1:0] dvd_reg, dvd_next;
    logic [2:0][DIVW-1:0] quo_reg, quo_next;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_comb
    begin
        logic [RW:0]     t;
        logic [RW-1:0]   r;
        logic [DIVW-1:0] d;
        logic [DIVW-1:0] q;
        for (int l = 0; l < 3; l++)
        begin
            r = rem_reg[l];
            d = dvd_reg[l];
            q = quo_reg[l];
            for (int j = 0; j < 4; j++)
            begin
                t = {r, d[DIVW-1]};
                d = {d[DIVW-2:0], 1'b0};
                if (t >= (RW+1)'(WINDOW))
                begin
                    t = t - (RW+1)'(WINDOW);
                    q = {q[DIVW-2:0], 1'b1};
                end
                else
                begin
                    q = {q[DIVW-2:0], 1'b0};
                end
                r = t[RW-1:0];
            end
            rem_next[l] = r;
            dvd_next[l] = d;
            quo_next[l] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CW'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int l = 0; l < 3; l++)
            begin
                dvd_reg[l] <= DIVW'(mag[l]);
                rem_reg[l] <= '0;
                quo_reg[l] <= '0;
            end
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            quo[l] = quo_reg[l][31:0];
        end
    end

    assign done = done_reg;

endmodule

FILE: rtl/mecanum_odometry_integrator.sv
// update: the shared multiplier forms eleven products and the mean divider runs between
// the time and position products; other opcodes only pass through S_MISC. a result still
// held on the output keeps the item waiting in S_OUT.
// throughput: one item at a time; the next is taken once the result is registered.
// reset: asynchronous active low; gains, sums, means, positions, time and the
// window valid bits clear at once, so no clearing pass is needed.
`timescale 1ns / 1ps

module mecanum_odometry_integrator import moi_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [GAIN_W-1:0]         cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                opcode,
    input  logic signed [SPEED_W-1:0] front_left_speed,
    input  logic signed [SPEED_W-1:0] front_right_speed,
    input  logic signed [SPEED_W-1:0] rear_left_speed,
    input  logic signed [SPEED_W-1:0] rear_right_speed,
    input  logic [TIME_W-1:0]         time_ns,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SPEED_W-1:0] mean_vel_x,
    output logic signed [SPEED_W-1:0] mean_vel_y,
    output logic signed [SPEED_W-1:0] mean_ang_vel,
    output logic signed [POS_W-1:0]   position_x,
    output logic signed [POS_W-1:0]   position_y,
    output logic signed [POS_W-1:0]   heading_angle
);

    localparam int SW   = $clog2(WINDOW);
    localparam int SUMW = SPEED_W + $clog2(WINDOW);
    localparam int EW   = 3 * SPEED_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MISC, S_VX, S_VY, S_VW, S_T0, S_T1, S_SUM,
        S_DIV, S_DWAIT, S_I0, S_I1, S_I2, S_OUT
    } state_t;

    state_t state_reg;

    logic [1:0]          op_reg;
    logic [SPEED_W-1:0]  fl_reg, fr_reg, rl_reg, rr_reg;
    logic [TIME_W-1:0]   now_reg, prev_time_reg;
    logic [GAIN_W-1:0]   lin_reg, ang_reg;
    logic [SW-1:0]       slot_reg;
    logic [WINDOW-1:0]   valid_reg;
    logic [SUMW-1:0]     sum_reg [3];
    logic [31:0]         vel_reg [3];
    logic [31:0]         mmag_reg [3];
    logic                mneg_reg [3];
    logic [POS_W-1:0]    pos_reg [3];
    logic [64:0]         plo_reg;
    logic [63:0]         secs_reg;
    logic [63:0]         ilo_reg;
    logic                dtneg_reg;
    logic [1:0]          axis_reg;
    logic                out_valid_reg;
    logic [SPEED_W-1:0]  om_reg [3];
    logic [POS_W-1:0]    op_pos_reg [3];

    // wheel combinations and their magnitudes
    logic [MUL_W-1:0] cx, cy, cw, mx, my, mw;
    logic [MUL_W-1:0] efl, efr, erl, err;

    assign efl = {{2{fl_reg[31]}}, fl_reg};
    assign efr = {{2{fr_reg[31]}}, fr_reg};
    assign erl = {{2{rl_reg[31]}}, rl_reg};
    assign err = {{2{rr_reg[31]}}, rr_reg};
    assign cx  = efr + efl + erl + err;
    assign cy  = efr - efl + erl - err;
    assign cw  = efr - efl - erl + err;
    assign mx  = cx[MUL_W-1] ? (~cx + MUL_W'(1)) : cx;
    assign my  = cy[MUL_W-1] ? (~cy + MUL_W'(1)) : cy;
    assign mw  = cw[MUL_W-1] ? (~cw + MUL_W'(1)) : cw;

    logic             dt_neg;
    logic [TIME_W-1:0] dmag;

    assign dt_neg = now_reg < prev_time_reg;
    assign dmag   = dt_neg ? (prev_time_reg - now_reg) : (now_reg - prev_time_reg);

    // shared multiplier
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_VX:
            begin
                mul_a = mx;
                mul_b = {2'b00, lin_reg};
            end
            S_VY:
            begin
                mul_a = my;
                mul_b = {2'b00, lin_reg};
            end
            S_VW:
            begin
                mul_a = mw;
                mul_b = {2'b00, ang_reg};
            end
            S_T0:
            begin
                mul_a = {2'b00, dmag[31:0]};
                mul_b = {1'b0, SEC_RECIP};
            end
            S_T1:
            begin
                mul_a = {3'b000, dmag[62:32]};
                mul_b = {1'b0, SEC_RECIP};
            end
            S_I0:
            begin
                mul_a = {2'b00, mmag_reg[axis_reg]};
                mul_b = {2'b00, secs_reg[31:0]};
            end
            S_I1:
            begin
                mul_a = {2'b00, mmag_reg[axis_reg]};
                mul_b = {2'b00, secs_reg[63:32]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    moi_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    logic [EW-1:0] mem_rdata;

    moi_wmem #(
        .DEPTH (WINDOW),
        .AW    (SW),
        .DW    (EW)
    ) u_wmem (
        .clk   (clk),
        .re    (state_reg == S_VX),
        .raddr (slot_reg),
        .rdata (mem_rdata),
        .we    (state_reg == S_SUM),
        .waddr (slot_reg),
        .wdata ({vel_reg[2], vel_reg[1], vel_reg[0]})
    );

    // running sums: add the new velocity, drop the one it replaces
    logic [SUMW-1:0]    sum_next [3];
    logic [SPEED_W-1:0] old_v;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            old_v = valid_reg[slot_reg] ? mem_rdata[k*SPEED_W +: SPEED_W] : '0;
            sum_next[k] = sum_reg[k]
                + {{(SUMW-SPEED_W){vel_reg[k][31]}}, vel_reg[k]}
                - {{(SUMW-SPEED_W){old_v[31]}}, old_v};
        end
    end

    logic [95:0] secs_full;
    assign secs_full = {31'd0, plo_reg} + {mul_p[63:0], 32'd0};

    logic [2:0][SUMW-1:0] div_mag;
    logic [2:0][31:0]     div_quo;
    logic                 div_done;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            div_mag[k] = sum_reg[k][SUMW-1] ? (~sum_reg[k] + SUMW'(1)) : sum_reg[k];
        end
    end

    moi_div #(
        .WINDOW (WINDOW),
        .SUMW   (SUMW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIV),
        .mag   (div_mag),
        .quo   (div_quo),
        .done  (div_done)
    );

    // position step: increment clamped to 2^48, then position clamped
    logic [95:0]       inc_full;
    logic [65:0]       inc_raw;
    logic [48:0]       inc;
    logic [POS_W+1:0]  pos_ext, pos_sum;
    logic [POS_W-1:0]  pos_new;

    always_comb
    begin
        inc_full = {32'd0, ilo_reg} + {mul_p[63:0], 32'd0};
        inc_raw  = inc_full[95:30];
        inc      = (inc_raw > {17'd0, 1'b1, 48'd0}) ? {1'b1, 48'd0} : inc_raw[48:0];
        pos_ext  = {{2{pos_reg[axis_reg][POS_W-1]}}, pos_reg[axis_reg]};
        if (mneg_reg[axis_reg] != dtneg_reg)
        begin
            pos_sum = pos_ext - {1'b0, inc};
        end
        else
        begin
            pos_sum = pos_ext + {1'b0, inc};
        end
        if (!pos_sum[POS_W+1] && (pos_sum[POS_W:POS_W-1] != 2'b00))
        begin
            pos_new = {1'b0, {(POS_W-1){1'b1}}};
        end
        else if (pos_sum[POS_W+1] && (pos_sum[POS_W:POS_W-1] != 2'b11))
        begin
            pos_new = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            pos_new = pos_sum[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lin_reg       <= '0;
            ang_reg       <= '0;
            slot_reg      <= '0;
            valid_reg     <= '0;
            prev_time_reg <= '0;
            axis_reg      <= '0;
            dtneg_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]  <= '0;
                mmag_reg[k] <= '0;
                mneg_reg[k] <= 1'b0;
                pos_reg[k]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LINEAR:  lin_reg <= cfg_data;
                    CFG_ANGULAR: ang_reg <= cfg_data;
                endcase
            end

            // in S_OUT the new beat takes the place of the one leaving
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= opcode;
                        fl_reg    <= front_left_speed;
                        fr_reg    <= front_right_speed;
                        rl_reg    <= rear_left_speed;
                        rr_reg    <= rear_right_speed;
                        now_reg   <= time_ns;
                        state_reg <= (opcode == OP_UPDATE) ? S_VX : S_MISC;
                    end
                end
                S_MISC:
                begin
                    if (op_reg == OP_INIT)
                    begin
                        valid_reg     <= '0;
                        prev_time_reg <= now_reg;
                        for (int k = 0; k < 3; k++)
                        begin
                            sum_reg[k]  <= '0;
                            mmag_reg[k] <= '0;
                            mneg_reg[k] <= 1'b0;
                        end
                    end
                    else if (op_reg == OP_POS_RESET)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            pos_reg[k] <= '0;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_VX:
                begin
                    state_reg <= S_VY;
                end
                S_VY:
                begin
                    vel_reg[0] <= vel_sat(mul_p, cx[MUL_W-1]);
                    state_reg  <= S_VW;
                end
                S_VW:
                begin
                    vel_reg[1] <= vel_sat(mul_p, cy[MUL_W-1]);
                    state_reg  <= S_T0;
                end
                S_T0:
                begin
                    vel_reg[2] <= vel_sat(mul_p, cw[MUL_W-1]);
                    dtneg_reg  <= dt_neg;
                    state_reg  <= S_T1;
                end
                S_T1:
                begin
                    plo_reg   <= mul_p[64:0];
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    secs_reg            <= secs_full[95:32];
                    valid_reg[slot_reg] <= 1'b1;
                    slot_reg            <= (slot_reg == SW'(WINDOW - 1)) ? '0
                                                                         : slot_reg + SW'(1);
                    prev_time_reg       <= now_reg;
                    for (int k = 0; k < 3; k++)
                    begin
                        sum_reg[k] <= sum_next[k];
                    end
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            mmag_reg[k] <= div_quo[k];
                            mneg_reg[k] <= sum_reg[k][SUMW-1];
                        end
                        axis_reg  <= '0;
                        state_reg <= S_I0;
                    end
                end
                S_I0:
                begin
                    state_reg <= S_I1;
                end
                S_I1:
                begin
                    ilo_reg   <= mul_p[63:0];
                    state_reg <= S_I2;
                end
                S_I2:
                begin
                    pos_reg[axis_reg] <= pos_new;
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_I0;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        for (int k = 0; k < 3; k++)
                        begin
                            om_reg[k]     <= mneg_reg[k] ? (~mmag_reg[k] + 32'd1)
                                                         : mmag_reg[k];
                            op_pos_reg[k] <= pos_reg[k];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign mean_vel_x    = om_reg[0];
    assign mean_vel_y    = om_reg[1];
    assign mean_ang_vel  = om_reg[2];
    assign position_x    = op_pos_reg[0];
    assign position_y    = op_pos_reg[1];
    assign heading_angle = op_pos_reg[2];

endmodule

FILE: rtl/moi_chk.sv
// port level checks for the mecanum odometry integrator, bound to the top level
// depends on moi_pkg
`timescale 1ns / 1ps

module moi_chk import moi_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [POS_W-1:0] position_x
);

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position_x))
        else $error("result beat changed while stalled");

    // one item at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a result appears only while an item is being worked on
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result beat without an item in flight");

endmodule

bind mecanum_odometry_integrator moi_chk u_moi_chk (.*);
